// ===== rtl/ivl_pkg.sv =====
// shared types and constants of the indexed value list
`default_nettype none
package ivl_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ActionW = 4;
  localparam int unsigned PosW = 6;
  localparam int unsigned ValueW = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW = 7;

  typedef enum logic [ActionW-1:0] {
    ACT_APPEND       = 4'd0,
    ACT_PREPEND      = 4'd1,
    ACT_READ_FIRST   = 4'd2,
    ACT_READ_LAST    = 4'd3,
    ACT_REMOVE_FIRST = 4'd4,
    ACT_REMOVE_LAST  = 4'd5,
    ACT_INSERT_AT    = 4'd6,
    ACT_READ_AT      = 4'd7,
    ACT_COUNT        = 4'd8
  } action_e;

  typedef enum logic [StatusW-1:0] {
    STAT_DONE   = 3'd0,
    STAT_VALID  = 3'd1,
    STAT_EMPTY  = 3'd2,
    STAT_BADIDX = 3'd3,
    STAT_FULL   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DISPLAY
  } state_e;

  typedef struct packed {
    logic            ins;
    logic            rem_first;
    logic [PosW-1:0] idx;
  } chain_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/ivl_in_if.sv =====
// request channel of the indexed value list
`default_nettype none
interface ivl_in_if;
  logic                              valid;
  logic                              ready;
  logic [ivl_pkg::ActionW-1:0]       action;
  logic                              show_all;
  logic [ivl_pkg::PosW-1:0]          position;
  logic signed [ivl_pkg::ValueW-1:0] item_value;

  modport source (output valid, action, show_all, position, item_value, input ready);
  modport sink (input valid, action, show_all, position, item_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/ivl_out_if.sv =====
// result channel of the indexed value list
`default_nettype none
interface ivl_out_if;
  logic                              valid;
  logic                              ready;
  logic [ivl_pkg::StatusW-1:0]       status;
  logic signed [ivl_pkg::ValueW-1:0] read_value;
  logic [ivl_pkg::CountW-1:0]        entry_count;
  logic                              last_of_run;

  modport source (output valid, status, read_value, entry_count, last_of_run, input ready);
  modport sink (input valid, status, read_value, entry_count, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/indexed_value_list_core.sv =====
// top level of the indexed value list
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// entry 0 first. Every operation except a display is done at once: inserts shift
// the cells from the insert position upward, remove-first shifts the whole row,
// reads pick one cell, and the result is held in an output register. A display
// of N entries emits N results, one per cycle while the result channel takes
// them; no new request is taken until its last result is registered. A request
// is taken in idle whenever the output register is empty or being drained, so
// the sustained rate is one request per cycle for all operations but display.
`default_nettype none
module indexed_value_list_core #(
  parameter int unsigned CAPACITY = ivl_pkg::DefCapacity
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  ivl_in_if.sink       req_i,
  ivl_out_if.source    rsp_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam logic [ivl_pkg::CountW-1:0] CapCnt = ivl_pkg::CountW'(CAPACITY);

  ivl_pkg::state_e state_d, state_q;
  logic [ivl_pkg::CountW-1:0] count_d, count_q;
  logic [IdxW-1:0]            disp_d, disp_q;
  logic                       out_valid_q;
  logic [ivl_pkg::StatusW-1:0] res_status_d, res_status_q;
  logic [ivl_pkg::ValueW-1:0]  res_value_d, res_value_q;
  logic [ivl_pkg::CountW-1:0]  res_count_q;
  logic                        res_last_d, res_last_q;

  logic                       slot_free, in_ready, in_fire, out_load, disp_start;
  ivl_pkg::chain_cmd_t        cmd;
  logic [IdxW-1:0]            rd_idx;
  logic [ivl_pkg::ValueW-1:0] rd_data;
  ivl_pkg::action_e           action;
  logic [ivl_pkg::CountW-1:0] pos_ext, count_m1;
  logic                       empty, full;

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign in_fire   = req_i.valid && in_ready;
  assign action    = ivl_pkg::action_e'(req_i.action);
  assign pos_ext   = ivl_pkg::CountW'(req_i.position);
  assign count_m1  = count_q - ivl_pkg::CountW'(1);
  assign empty     = (count_q == '0);
  assign full      = (count_q >= CapCnt);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ivl_pkg::ST_IDLE: begin
        if (disp_start) state_d = ivl_pkg::ST_DISPLAY;
      end
      ivl_pkg::ST_DISPLAY: begin
        if (slot_free && res_last_d) state_d = ivl_pkg::ST_IDLE;
      end
      default: state_d = ivl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    out_load     = 1'b0;
    disp_start   = 1'b0;
    res_status_d = ivl_pkg::STAT_DONE;
    res_value_d  = '0;
    res_last_d   = 1'b1;
    cmd          = '0;
    rd_idx       = '0;
    count_d      = count_q;
    disp_d       = disp_q;
    unique case (state_q)
      ivl_pkg::ST_IDLE: begin
        in_ready = slot_free;
        out_load = in_fire;
        case (action)
          ivl_pkg::ACT_READ_LAST: rd_idx = count_m1[IdxW-1:0];
          ivl_pkg::ACT_READ_AT:   rd_idx = req_i.position[IdxW-1:0];
          default:                rd_idx = '0;
        endcase
        if (in_fire) begin
          case (action)
            ivl_pkg::ACT_APPEND, ivl_pkg::ACT_PREPEND: begin
              if (full) begin
                res_status_d = ivl_pkg::STAT_FULL;
              end else begin
                cmd.ins = 1'b1;
                cmd.idx = (action == ivl_pkg::ACT_APPEND) ? count_q[ivl_pkg::PosW-1:0] : '0;
                count_d = count_q + ivl_pkg::CountW'(1);
              end
            end
            ivl_pkg::ACT_READ_FIRST, ivl_pkg::ACT_READ_LAST: begin
              if (empty) begin
                res_status_d = ivl_pkg::STAT_EMPTY;
              end else begin
                res_status_d = ivl_pkg::STAT_VALID;
                res_value_d  = rd_data;
              end
            end
            ivl_pkg::ACT_REMOVE_FIRST, ivl_pkg::ACT_REMOVE_LAST: begin
              if (empty) begin
                res_status_d = ivl_pkg::STAT_EMPTY;
              end else begin
                cmd.rem_first = (action == ivl_pkg::ACT_REMOVE_FIRST);
                count_d       = count_m1;
              end
            end
            ivl_pkg::ACT_INSERT_AT: begin
              if (pos_ext > count_q) begin
                res_status_d = ivl_pkg::STAT_BADIDX;
              end else if (full) begin
                res_status_d = ivl_pkg::STAT_FULL;
              end else begin
                cmd.ins = 1'b1;
                cmd.idx = req_i.position;
                count_d = count_q + ivl_pkg::CountW'(1);
              end
            end
            ivl_pkg::ACT_READ_AT: begin
              if (empty) begin
                res_status_d = ivl_pkg::STAT_EMPTY;
              end else if (pos_ext >= count_q) begin
                res_status_d = ivl_pkg::STAT_BADIDX;
              end else begin
                res_status_d = ivl_pkg::STAT_VALID;
                res_value_d  = rd_data;
              end
            end
            ivl_pkg::ACT_COUNT: begin
              if (empty) begin
                res_status_d = ivl_pkg::STAT_EMPTY;
              end else if (!req_i.show_all) begin
                res_status_d = ivl_pkg::STAT_VALID;
                res_value_d  = ivl_pkg::ValueW'(count_q);
              end else begin
                res_status_d = ivl_pkg::STAT_VALID;
                res_value_d  = rd_data;
                res_last_d   = (count_q == ivl_pkg::CountW'(1));
                disp_start   = !res_last_d;
                disp_d       = IdxW'(1);
              end
            end
            default: res_status_d = ivl_pkg::STAT_DONE;
          endcase
        end
      end
      ivl_pkg::ST_DISPLAY: begin
        rd_idx       = disp_q;
        out_load     = slot_free;
        res_status_d = ivl_pkg::STAT_VALID;
        res_value_d  = rd_data;
        res_last_d   = ((ivl_pkg::CountW'(disp_q) + ivl_pkg::CountW'(1)) == count_q);
        if (slot_free) disp_d = disp_q + IdxW'(1);
      end
      default: ;
    endcase
  end

  ivl_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .load_i    (req_i.item_value),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ivl_pkg::ST_IDLE;
      count_q     <= '0;
      disp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      disp_q  <= disp_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      res_count_q  <= count_d;
      res_last_q   <= res_last_d;
    end
  end

  assign req_i.ready       = in_ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = res_status_q;
  assign rsp_o.read_value  = res_value_q;
  assign rsp_o.entry_count = res_count_q;
  assign rsp_o.last_of_run = res_last_q;

endmodule
`default_nettype wire

// ===== rtl/ivl_cell.sv =====
// one storage cell of the list chain
`default_nettype none
module ivl_cell (
  input  wire                               clk_i,
  input  wire ivl_pkg::cell_op_e            op_i,
  input  wire logic [ivl_pkg::ValueW-1:0]   from_left_i,
  input  wire logic [ivl_pkg::ValueW-1:0]   from_right_i,
  input  wire logic [ivl_pkg::ValueW-1:0]   load_i,
  output logic [ivl_pkg::ValueW-1:0]        value_o
);

  logic [ivl_pkg::ValueW-1:0] value_d, value_q;

  always_comb begin
    case (op_i)
      ivl_pkg::CELL_LOAD:       value_d = load_i;
      ivl_pkg::CELL_FROM_LEFT:  value_d = from_left_i;
      ivl_pkg::CELL_FROM_RIGHT: value_d = from_right_i;
      default:                  value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
`default_nettype wire

// ===== rtl/ivl_chain.sv =====
// row of cells with shift control and read select
`default_nettype none
module ivl_chain #(
  parameter int unsigned CAPACITY = ivl_pkg::DefCapacity,
  localparam int unsigned IdxW = $clog2(CAPACITY)
) (
  input  wire                               clk_i,
  input  wire ivl_pkg::chain_cmd_t          cmd_i,
  input  wire logic [ivl_pkg::ValueW-1:0]   load_i,
  input  wire logic [IdxW-1:0]              rd_idx_i,
  output logic [ivl_pkg::ValueW-1:0]        rd_data_o
);

  logic [ivl_pkg::ValueW-1:0] cell_val [CAPACITY];
  ivl_pkg::cell_op_e          cell_op  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ivl_pkg::ValueW-1:0] left_val, right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    always_comb begin
      cell_op[i] = ivl_pkg::CELL_HOLD;
      if (cmd_i.ins) begin
        if (ivl_pkg::PosW'(i) > cmd_i.idx) begin
          cell_op[i] = ivl_pkg::CELL_FROM_LEFT;
        end else if (ivl_pkg::PosW'(i) == cmd_i.idx) begin
          cell_op[i] = ivl_pkg::CELL_LOAD;
        end
      end else if (cmd_i.rem_first && (i < CAPACITY - 1)) begin
        cell_op[i] = ivl_pkg::CELL_FROM_RIGHT;
      end
    end

    ivl_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (cell_op[i]),
      .from_left_i  (left_val),
      .from_right_i (right_val),
      .load_i       (load_i),
      .value_o      (cell_val[i])
    );
  end

  assign rd_data_o = cell_val[rd_idx_i];

endmodule
`default_nettype wire

// ===== bench/indexed_value_list_core_tb.sv =====
// testbench of indexed_value_list_core with a shadow list and random idle cycles
`default_nettype none
module indexed_value_list_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ivl_pkg::*;

  localparam int Capacity = DefCapacity;
  localparam int NumPhases = 6;
  localparam int ItemsPerPhase = 36;

  typedef struct {
    status_e                  status;
    logic signed [ValueW-1:0] value;
    logic [CountW-1:0]        count;
    logic                     last;
  } list_result_t;

  class list_shadow;
    logic signed [ValueW-1:0] cells [Capacity];
    int                       held;
    int                       errors;
    list_result_t             pending_results [$];

    function new();
      held = 0;
      errors = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function void push(status_e st, logic signed [ValueW-1:0] v, logic last);
      list_result_t r;
      r.status = st;
      r.value  = v;
      r.count  = CountW'(held);
      r.last   = last;
      pending_results.push_back(r);
    endfunction

    function void insert_cell(int idx, logic signed [ValueW-1:0] v);
      for (int i = held; i > idx; i--) cells[i] = cells[i-1];
      cells[idx] = v;
      held++;
    endfunction

    // apply one accepted transaction and queue the results it causes
    function void note_request(logic [ActionW-1:0] act, logic show, logic [PosW-1:0] pos,
                               logic signed [ValueW-1:0] v);
      case (act)
        ACT_APPEND, ACT_PREPEND: begin
          if (held >= Capacity) begin
            push(STAT_FULL, '0, 1'b1);
          end else begin
            insert_cell((act == ACT_APPEND) ? held : 0, v);
            push(STAT_DONE, '0, 1'b1);
          end
        end
        ACT_READ_FIRST, ACT_READ_LAST: begin
          if (held == 0) push(STAT_EMPTY, '0, 1'b1);
          else push(STAT_VALID, cells[(act == ACT_READ_FIRST) ? 0 : held - 1], 1'b1);
        end
        ACT_REMOVE_FIRST: begin
          if (held == 0) begin
            push(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i + 1 < held; i++) cells[i] = cells[i+1];
            held--;
            push(STAT_DONE, '0, 1'b1);
          end
        end
        ACT_REMOVE_LAST: begin
          if (held == 0) begin
            push(STAT_EMPTY, '0, 1'b1);
          end else begin
            held--;
            push(STAT_DONE, '0, 1'b1);
          end
        end
        ACT_INSERT_AT: begin
          if (int'(pos) > held) push(STAT_BADIDX, '0, 1'b1);
          else if (held >= Capacity) push(STAT_FULL, '0, 1'b1);
          else begin
            insert_cell(int'(pos), v);
            push(STAT_DONE, '0, 1'b1);
          end
        end
        ACT_READ_AT: begin
          if (held == 0) push(STAT_EMPTY, '0, 1'b1);
          else if (int'(pos) >= held) push(STAT_BADIDX, '0, 1'b1);
          else push(STAT_VALID, cells[pos], 1'b1);
        end
        ACT_COUNT: begin
          if (held == 0) push(STAT_EMPTY, '0, 1'b1);
          else if (!show) push(STAT_VALID, ValueW'(held), 1'b1);
          else for (int i = 0; i < held; i++) push(STAT_VALID, cells[i], i + 1 == held);
        end
        default: push(STAT_DONE, '0, 1'b1);
      endcase
    endfunction

    function void check_result(logic [StatusW-1:0] st, logic signed [ValueW-1:0] v,
                               logic [CountW-1:0] c, logic last);
      list_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d value %0d count %0d last %0d",
                 $time, st, v, c, last);
        return;
      end
      e = pending_results.pop_front();
      if (st !== e.status || v !== e.value || c !== e.count || last !== e.last) begin
        errors++;
        $display({"%0t: mismatch: expected status %0d value %0d count %0d last %0d,",
                  " got status %0d value %0d count %0d last %0d"},
                 $time, e.status, e.value, e.count, e.last, st, v, c, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet = 1'b0;

  list_shadow shadow = new();

  ivl_in_if  req_if ();
  ivl_out_if rsp_if ();

  indexed_value_list_core #(
    .CAPACITY(Capacity)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_request(input logic [ActionW-1:0] act, input logic show,
                              input logic [PosW-1:0] pos, input logic signed [ValueW-1:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.show_all   <= show;
    req_if.position   <= pos;
    req_if.item_value <= val;
    do @(posedge clk); while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
    shadow.note_request(act, show, pos, val);
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return {1'b0, {(ValueW-1){1'b1}}};
      1: return {1'b1, {(ValueW-1){1'b0}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // mostly in-range positions, sometimes anywhere in the field
  function automatic logic [PosW-1:0] pick_pos(int top);
    if (top < 0 || $urandom_range(0, 6) == 0) return PosW'($urandom_range(0, (1 << PosW) - 1));
    return PosW'($urandom_range(0, top));
  endfunction

  task automatic send_random(input int ins_pct, input int rem_pct, output bit known);
    int                       r;
    logic [ActionW-1:0]       act;
    logic [PosW-1:0]          pos;
    logic signed [ValueW-1:0] val;
    r = $urandom_range(0, 99);
    known = 1'b1;
    pos = PosW'($urandom_range(0, (1 << PosW) - 1));
    val = pick_value();
    if (r < ins_pct) begin
      case ($urandom_range(0, 2))
        0: act = ACT_APPEND;
        1: act = ACT_PREPEND;
        default: begin
          act = ACT_INSERT_AT;
          pos = pick_pos(shadow.held);
        end
      endcase
    end else if (r < ins_pct + rem_pct) begin
      act = $urandom_range(0, 1) ? ACT_REMOVE_FIRST : ACT_REMOVE_LAST;
    end else if (r < 90) begin
      case ($urandom_range(0, 2))
        0: act = ACT_READ_FIRST;
        1: act = ACT_READ_LAST;
        default: begin
          act = ACT_READ_AT;
          pos = pick_pos(shadow.held - 1);
        end
      endcase
    end else if (r < 97) begin
      act = ACT_COUNT;
    end else begin
      act = ActionW'($urandom_range(int'(ACT_COUNT) + 1, (1 << ActionW) - 1));
      known = 1'b0;
    end
    send_request(act, 1'($urandom_range(0, 1)), pos, val);
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      int stall;
      stall = quiet ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
      shadow.check_result(rsp_if.status, rsp_if.read_value, rsp_if.entry_count,
                          rsp_if.last_of_run);
    end
  end

  initial begin
    int  ins_pct [NumPhases];
    int  rem_pct [NumPhases];
    int  sent;
    bit  known;
    ins_pct = '{55, 35, 15, 55, 35, 15};
    rem_pct = '{15, 30, 55, 15, 30, 55};
    rst_n             <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.action     <= '0;
    req_if.show_all   <= 1'b0;
    req_if.position   <= '0;
    req_if.item_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list
    send_request(ACT_READ_FIRST, 1'b0, '0, '0);
    send_request(ACT_READ_LAST, 1'b0, '0, '0);
    send_request(ACT_REMOVE_FIRST, 1'b0, '0, '0);
    send_request(ACT_REMOVE_LAST, 1'b1, '0, '0);
    send_request(ACT_READ_AT, 1'b0, '0, '0);
    send_request(ACT_COUNT, 1'b0, '0, '0);
    send_request(ACT_COUNT, 1'b1, '0, '0);
    send_request(ACT_INSERT_AT, 1'b0, PosW'(1), '0);
    send_request('1, 1'b1, '1, '1);

    // build up with extreme values, then fill
    send_request(ACT_INSERT_AT, 1'b0, '0, {1'b0, {(ValueW-1){1'b1}}});
    send_request(ACT_APPEND, 1'b0, '0, {1'b1, {(ValueW-1){1'b0}}});
    send_request(ACT_PREPEND, 1'b1, '1, '1);
    send_request(ACT_INSERT_AT, 1'b0, PosW'(3), '0);
    while (shadow.held < Capacity) send_request(ACT_APPEND, 1'b0, '0, $urandom);

    // full list
    send_request(ACT_APPEND, 1'b0, '0, '1);
    send_request(ACT_PREPEND, 1'b0, '0, '1);
    send_request(ACT_INSERT_AT, 1'b0, PosW'(Capacity), '1);
    send_request(ACT_INSERT_AT, 1'b0, PosW'(Capacity + 1), '1);
    send_request(ACT_READ_AT, 1'b0, PosW'(Capacity - 1), '0);
    send_request(ACT_READ_AT, 1'b0, '1, '0);
    send_request(ACT_COUNT, 1'b1, '0, '0);
    send_request(ACT_REMOVE_FIRST, 1'b0, '0, '0);
    send_request(ACT_REMOVE_LAST, 1'b0, '0, '0);
    send_request(ACT_COUNT, 1'b0, '0, '0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      quiet = (ph == 4);
      sent = 0;
      while (sent < ItemsPerPhase) begin
        send_random(ins_pct[ph], rem_pct[ph], known);
        if (known) sent++;
      end
    end
    req_if.valid <= 1'b0;
    quiet = 1'b0;

    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.pending_results.size() != 0) begin
      shadow.errors++;
      $display("%0t: %0d expected results never arrived", $time,
               shadow.pending_results.size());
    end
    if (shadow.errors == 0) begin
      $display("indexed_value_list_core_tb: done, clean");
    end else begin
      $display("indexed_value_list_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("indexed_value_list_core_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
